// ----- src/srf_pkg.sv -----
// Shared types and constants of the signed radix formatter.
`default_nettype none

package srf_pkg;

  localparam int SYM_W       = 8;
  localparam int COUNT_W     = 6;
  localparam int DIGIT_W     = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int SYMS_PER_REG = 8;
  localparam int DIV_BITS_PER_CYCLE = 8;

  localparam logic [SYM_W-1:0]   CHAR_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0]   CHAR_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0]   PRINT_LO    = 8'd32;
  localparam logic [SYM_W-1:0]   PRINT_HI    = 8'd126;
  localparam logic [COUNT_W-1:0] MIN_SYMBOLS = 6'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYMBOL_COUNT   = 3'd0,
    REG_ALPHA_LOW      = 3'd1,
    REG_ALPHA_MID_LOW  = 3'd2,
    REG_ALPHA_MID_HIGH = 3'd3,
    REG_ALPHA_HIGH     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic chk_next;
    logic div_step;
    logic rd;
    logic out_err;
    logic out_sign;
    logic out_digit;
  } cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic chk_last;
    logic step_last;
    logic quo_next_zero;
    logic neg;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/srf_if.sv -----
// Channel interfaces of the signed radix formatter.
`default_nettype none

interface srf_value_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface srf_result_if;
  logic                       valid;
  logic                       ready;
  logic [srf_pkg::SYM_W-1:0]  symbol;
  logic                       final_symbol;
  logic                       alphabet_error;
  modport source (output valid, output symbol, output final_symbol, output alphabet_error,
                  input ready);
  modport sink (input valid, input symbol, input final_symbol, input alphabet_error,
                output ready);
endinterface

interface srf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [srf_pkg::CFG_INDEX_W-1:0] index;
  logic [srf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/signed_radix_formatter_core.sv -----
// Top level of the signed radix formatter: controller and datapath.
// One item at a time: the magnitude is divided by the symbol count until the quotient is zero,
// then an optional minus sign and the digits, most significant first, are emitted as taken.
// The divider retires 8 quotient bits per cycle; each symbol needs a stack read then a load.
// An invalid alphabet yields one error result.
// Reset clears configuration and control; the digit stack is not cleared.
`default_nettype none

module signed_radix_formatter_core #(
  parameter int MAX_SYMBOLS = 32,
  parameter int VALUE_BITS  = 32
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  srf_value_if.sink    value_i,
  srf_result_if.source result_o,
  srf_cfg_if.sink      cfg_i
);

  srf_pkg::cmd_t cmd;
  srf_pkg::sts_t sts;
  logic          in_ready;

  assign value_i.ready = in_ready;
  assign cfg_i.ready   = 1'b1;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (value_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srf_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .value_i      (VALUE_BITS'(value_i.value)),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .out_symbol_o (result_o.symbol),
    .out_final_o  (result_o.final_symbol),
    .out_error_o  (result_o.alphabet_error)
  );

endmodule

`default_nettype wire

// ----- src/srf_ctrl.sv -----
// Sequencing state machine of the signed radix formatter.
`default_nettype none

module srf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire srf_pkg::sts_t sts_i,
  output srf_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.chk_next = 1'b1;
        priority if (sts_i.chk_fail) begin
          state_d = ST_ERR;
        end else if (sts_i.chk_last) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.out_err = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last && sts_i.quo_next_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.out_sign = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_digit = 1'b1;
          state_d         = sts_i.cnt_zero ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/srf_datapath.sv -----
// Datapath: configuration, alphabet check, radix divider, digit stack, output register.
`default_nettype none

module srf_datapath #(
  parameter int MAX_SYMBOLS = 32,
  parameter int VALUE_BITS  = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [srf_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [srf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [VALUE_BITS-1:0]             value_i,
  input  wire srf_pkg::cmd_t                     cmd_i,
  output srf_pkg::sts_t                          sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [srf_pkg::SYM_W-1:0]              out_symbol_o,
  output logic                                   out_final_o,
  output logic                                   out_error_o
);

  localparam int CW    = srf_pkg::COUNT_W;
  localparam int DW    = srf_pkg::DIGIT_W;
  localparam int SYMW  = srf_pkg::SYM_W;
  localparam int BPC   = srf_pkg::DIV_BITS_PER_CYCLE;
  localparam int STEPS = (VALUE_BITS + BPC - 1) / BPC;
  localparam int QW    = STEPS * BPC;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CNTW  = $clog2(VALUE_BITS + 1);
  localparam int IW    = $clog2(MAX_SYMBOLS);
  localparam int RPS   = srf_pkg::SYMS_PER_REG;

  logic [CW-1:0]   count_q;
  logic [SYMW-1:0] alpha_q [MAX_SYMBOLS];

  logic [IW-1:0]   chk_idx_q;
  logic [SW-1:0]   step_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q;
  logic [QW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   rd_q;
  logic [DW-1:0]   stack_q [VALUE_BITS];

  logic            out_valid_q;
  logic [SYMW-1:0] out_symbol_q;
  logic            out_final_q;
  logic            out_error_q;

  logic [VALUE_BITS-1:0] mag;
  logic [CW-1:0]         idx_ext;
  logic [SYMW-1:0]       sym_chk;
  logic                  count_bad;
  logic                  range_bad;
  logic                  dup;
  logic [QW-1:0]         quo_v;
  logic [DW-1:0]         rem_v;
  logic [CNTW-1:0]       cnt_dec;
  logic                  step_last;
  logic                  out_free;

  assign mag     = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
  assign idx_ext = CW'(chk_idx_q);
  assign sym_chk = alpha_q[chk_idx_q];

  assign count_bad = (count_q < srf_pkg::MIN_SYMBOLS) || (count_q > CW'(MAX_SYMBOLS));
  assign range_bad = (sym_chk < srf_pkg::PRINT_LO) || (sym_chk > srf_pkg::PRINT_HI) ||
                     (sym_chk == srf_pkg::CHAR_PLUS) || (sym_chk == srf_pkg::CHAR_MINUS);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((CW'(j) > idx_ext) && (CW'(j) < count_q) && (alpha_q[j] == sym_chk)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    logic [DW:0] part;
    logic        ge;
    quo_v = quo_q;
    rem_v = rem_q;
    for (int k = 0; k < BPC; k++) begin
      part  = {rem_v, quo_v[QW-1]};
      ge    = (part >= count_q);
      quo_v = {quo_v[QW-2:0], ge};
      rem_v = ge ? DW'(part - count_q) : part[DW-1:0];
    end
  end

  assign cnt_dec   = cnt_q - 1'b1;
  assign step_last = (step_q == SW'(STEPS - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.chk_fail      = count_bad || range_bad || dup;
  assign sts_o.chk_last      = (idx_ext == (count_q - 1'b1));
  assign sts_o.step_last     = step_last;
  assign sts_o.quo_next_zero = (quo_v == '0);
  assign sts_o.neg           = neg_q;
  assign sts_o.cnt_zero      = (cnt_q == '0);
  assign sts_o.out_free      = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int s = 0; s < MAX_SYMBOLS; s++) begin
        alpha_q[s] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == srf_pkg::REG_SYMBOL_COUNT) begin
        count_q <= cfg_data_i[CW-1:0];
      end
      for (int s = 0; s < MAX_SYMBOLS; s++) begin
        if (cfg_index_i == 3'(int'(srf_pkg::REG_ALPHA_LOW) + s / RPS)) begin
          alpha_q[s] <= cfg_data_i[(s % RPS) * SYMW +: SYMW];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_idx_q   <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        chk_idx_q <= '0;
        step_q    <= '0;
        cnt_q     <= '0;
        neg_q     <= value_i[VALUE_BITS-1];
      end
      if (cmd_i.chk_next) begin
        chk_idx_q <= chk_idx_q + 1'b1;
      end
      if (cmd_i.div_step) begin
        if (step_last) begin
          step_q <= '0;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (cmd_i.rd) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.out_err || cmd_i.out_sign || cmd_i.out_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q <= QW'(mag);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= quo_v;
      rem_q <= step_last ? '0 : rem_v;
      if (step_last) begin
        stack_q[cnt_q[AW-1:0]] <= rem_v;
      end
    end
    if (cmd_i.rd) begin
      rd_q <= stack_q[cnt_dec[AW-1:0]];
    end
    if (cmd_i.out_err) begin
      out_symbol_q <= '0;
      out_final_q  <= 1'b1;
      out_error_q  <= 1'b1;
    end else if (cmd_i.out_sign) begin
      out_symbol_q <= srf_pkg::CHAR_MINUS;
      out_final_q  <= 1'b0;
      out_error_q  <= 1'b0;
    end else if (cmd_i.out_digit) begin
      out_symbol_q <= alpha_q[rd_q[IW-1:0]];
      out_final_q  <= (cnt_q == '0);
      out_error_q  <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_symbol_q;
  assign out_final_o  = out_final_q;
  assign out_error_o  = out_error_q;

endmodule

`default_nettype wire

// ----- src/srf_checker.sv -----
// Port checker of the signed radix formatter and its bind.
`default_nettype none

module srf_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [srf_pkg::SYM_W-1:0] symbol_i,
  input wire logic                      final_symbol_i,
  input wire logic                      alphabet_error_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(symbol_i) &&
    $stable(final_symbol_i) && $stable(alphabet_error_i))
    else $error("result dropped or changed while stalled");

  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alphabet_error_i |-> final_symbol_i && (symbol_i == '0))
    else $error("error result not final or symbol nonzero");

  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !final_symbol_i |-> !in_ready_i)
    else $error("new request taken before the last symbol was queued");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready after accepting a request");

endmodule

bind signed_radix_formatter_core srf_checker u_srf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (value_i.valid),
  .in_ready_i       (value_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .symbol_i         (result_o.symbol),
  .final_symbol_i   (result_o.final_symbol),
  .alphabet_error_i (result_o.alphabet_error)
);

`default_nettype wire
